[rtl/core/tcf_pkg.sv]
// Shared constants and helpers for the tilt complementary filter.
// Holds the unit widths, the arctangent table and the Q16.16 saturation.
// No dependencies.
package tcf_pkg;

    // Width of one Q16.16 angle.
    localparam int AngW = 32;

    // Divider: magnitude of ticks*tick_seconds*rate over the gyro scale times 256.
    localparam int DivNumW = 56;
    localparam int DivDenW = 24;

    // Square root: radicand and root widths.
    localparam int SqrtRadW = 32;
    localparam int SqrtRootW = 16;

    // CORDIC vectoring steps and the 90 degree turn in Q16.16.
    localparam int CordicSteps = 20;
    localparam logic signed [AngW-1:0] Deg90Q16 = 32'sd5898240;

    // Width of the sums that are saturated back to Q16.16.
    localparam int WideW = 58;

    // atan(2^-i) in Q16.16 degrees, rounded to nearest.
    function automatic logic signed [AngW-1:0] atan_deg(input logic [4:0] step);
        logic signed [AngW-1:0] val;
        unique case (step)
            5'd0:    val = 32'sd2949120;
            5'd1:    val = 32'sd1740967;
            5'd2:    val = 32'sd919879;
            5'd3:    val = 32'sd466945;
            5'd4:    val = 32'sd234379;
            5'd5:    val = 32'sd117304;
            5'd6:    val = 32'sd58666;
            5'd7:    val = 32'sd29335;
            5'd8:    val = 32'sd14668;
            5'd9:    val = 32'sd7334;
            5'd10:   val = 32'sd3667;
            5'd11:   val = 32'sd1833;
            5'd12:   val = 32'sd917;
            5'd13:   val = 32'sd458;
            5'd14:   val = 32'sd229;
            5'd15:   val = 32'sd115;
            5'd16:   val = 32'sd57;
            5'd17:   val = 32'sd29;
            5'd18:   val = 32'sd14;
            5'd19:   val = 32'sd7;
            default: val = 32'sd0;
        endcase
        return val;
    endfunction

    // Clamp a wide signed sum to the signed 32 bit range.
    function automatic logic signed [AngW-1:0] sat32(input logic signed [WideW-1:0] v);
        logic signed [AngW-1:0] res;
        if (v > 58'sd2147483647)
        begin
            res = 32'sh7FFFFFFF;
        end
        else if (v < -58'sd2147483648)
        begin
            res = 32'sh80000000;
        end
        else
        begin
            res = v[AngW-1:0];
        end
        return res;
    endfunction

endpackage

[rtl/core/tcf_div.sv]
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Used for the three gyro increments. Depends on tcf_pkg.
module tcf_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tcf_pkg::DivNumW-1:0]  dividend,
    input  logic [tcf_pkg::DivDenW-1:0]  divisor,
    output logic [tcf_pkg::DivNumW-1:0]  quotient,
    output logic                         done
);

    localparam int CntW = $clog2(tcf_pkg::DivNumW);
    localparam logic [CntW-1:0] LastStep = CntW'(tcf_pkg::DivNumW - 1);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CntW-1:0]             cnt_reg, cnt_next;
    logic [tcf_pkg::DivDenW-1:0] rem_reg, rem_next;
    logic [tcf_pkg::DivNumW-1:0] quo_reg, quo_next;
    logic [tcf_pkg::DivDenW-1:0] den_reg, den_next;

    logic [tcf_pkg::DivDenW:0]   shifted;
    logic [tcf_pkg::DivDenW:0]   diff;
    logic                        fits;

    // One restoring step: bring in the next dividend bit and try the subtract.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[tcf_pkg::DivNumW-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = (shifted >= {1'b0, den_reg});
    end

    // Next-state logic for the run.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[tcf_pkg::DivDenW-1:0] : shifted[tcf_pkg::DivDenW-1:0];
            quo_next = {quo_reg[tcf_pkg::DivNumW-2:0], fits};
            if (cnt_reg == LastStep)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[rtl/core/tcf_isqrt.sv]
// Iterative integer square root, one root bit per cycle, truncated.
// Used for the accelerometer magnitude and the CORDIC leg. Depends on tcf_pkg.
module tcf_isqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [tcf_pkg::SqrtRadW-1:0]   radicand,
    output logic [tcf_pkg::SqrtRootW-1:0]  root,
    output logic                           done
);

    localparam int CntW = $clog2(tcf_pkg::SqrtRootW);
    localparam logic [CntW-1:0] LastStep = CntW'(tcf_pkg::SqrtRootW - 1);
    localparam int RemW = tcf_pkg::SqrtRootW + 2;

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CntW-1:0]               cnt_reg, cnt_next;
    logic [RemW-1:0]               rem_reg, rem_next;
    logic [tcf_pkg::SqrtRadW-1:0]  rad_reg, rad_next;
    logic [tcf_pkg::SqrtRootW-1:0] root_reg, root_next;

    logic [RemW+1:0]               shifted;
    logic [RemW+1:0]               trial;
    logic [RemW+1:0]               diff;
    logic                          fits;

    // One digit step: bring in two radicand bits and try 4*root+1.
    always_comb
    begin
        shifted = {rem_reg, rad_reg[tcf_pkg::SqrtRadW-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        diff    = shifted - trial;
        fits    = (shifted >= trial);
    end

    // Next-state logic for the run.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            rad_next  = radicand;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[RemW-1:0] : shifted[RemW-1:0];
            rad_next  = {rad_reg[tcf_pkg::SqrtRadW-3:0], 2'b00};
            root_next = {root_reg[tcf_pkg::SqrtRootW-2:0], fits};
            if (cnt_reg == LastStep)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

[rtl/core/tcf_cordic.sv]
// Iterative vectoring CORDIC that returns atan2(h, a) in Q16.16 degrees.
// One micro-rotation per cycle. Depends on tcf_pkg for the arctangent table.
module tcf_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [15:0]                a,
    input  logic [15:0]                       h,
    output logic signed [tcf_pkg::AngW-1:0]   angle,
    output logic                              done
);

    localparam int CntW = $clog2(tcf_pkg::CordicSteps);
    localparam logic [CntW-1:0] LastStep = CntW'(tcf_pkg::CordicSteps - 1);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [CntW-1:0]                 cnt_reg, cnt_next;
    logic signed [tcf_pkg::AngW-1:0] x_reg, x_next;
    logic signed [tcf_pkg::AngW-1:0] y_reg, y_next;
    logic signed [tcf_pkg::AngW-1:0] z_reg, z_next;

    logic signed [tcf_pkg::AngW-1:0] xs;
    logic signed [tcf_pkg::AngW-1:0] ys;
    logic signed [tcf_pkg::AngW-1:0] a_ext;
    logic signed [tcf_pkg::AngW-1:0] h_ext;
    logic signed [tcf_pkg::AngW-1:0] step_ang;
    logic                            y_pos;

    // Shifted copies and the direction of this micro-rotation.
    always_comb
    begin
        xs       = x_reg >>> cnt_reg;
        ys       = y_reg >>> cnt_reg;
        step_ang = tcf_pkg::atan_deg(5'(cnt_reg));
        y_pos    = !y_reg[tcf_pkg::AngW-1] && (y_reg != '0);
        a_ext    = tcf_pkg::AngW'(a);
        h_ext    = $signed({{(tcf_pkg::AngW-16){1'b0}}, h});
    end

    // Next-state logic: a negative a is first turned by -90 degrees.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            if (a[15])
            begin
                x_next = h_ext <<< 12;
                y_next = (-a_ext) <<< 12;
                z_next = tcf_pkg::Deg90Q16;
            end
            else
            begin
                x_next = a_ext <<< 12;
                y_next = h_ext <<< 12;
                z_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_pos)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + step_ang;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - step_ang;
            end
            if (cnt_reg == LastStep)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign angle = z_reg;
    assign done  = done_reg;

endmodule

[rtl/core/tilt_complementary_filter_top.sv]
// Tilt complementary filter: one accelerometer/gyro word in, one angle word out.
// A word runs through one 16-step square root for the accelerometer magnitude and
// the 56-step radix-2 divider, run once per axis for the gyro increments, followed
// by two 16-step square roots and two 20-step CORDIC runs for the x and y tilt;
// these last are skipped when the magnitude is zero. A single shared 41x18
// multiplier serves all products. in_ready is high only while idle. A finished
// word waits in the output register, and a new input word is taken meanwhile.
// Configuration writes are always accepted and must be made while the block is
// idle. Depends on tcf_pkg, tcf_div, tcf_isqrt and tcf_cordic.
module tilt_complementary_filter_top (
    input  logic               clk,
    input  logic               rst_n,
    // Configuration write channel.
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    // Input channel.
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] rate_x,
    input  logic signed [15:0] rate_y,
    input  logic signed [15:0] rate_z,
    input  logic [23:0]        elapsed_ticks,
    // Output channel.
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] angle_x_deg,
    output logic signed [15:0] angle_y_deg,
    output logic signed [15:0] angle_z_deg,
    output logic               no_gravity
);

    // Register indexes.
    localparam logic [1:0] CfgBlendWeight = 2'd0;
    localparam logic [1:0] CfgTickSeconds = 2'd1;
    localparam logic [1:0] CfgGyroScale   = 2'd2;

    // Sequencer states.
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_M_DT     = 5'd1;
    localparam logic [4:0] S_M_AX2    = 5'd2;
    localparam logic [4:0] S_M_AY2    = 5'd3;
    localparam logic [4:0] S_M_AZ2    = 5'd4;
    localparam logic [4:0] S_SQ_SUM   = 5'd5;
    localparam logic [4:0] S_G_GO     = 5'd6;
    localparam logic [4:0] S_G_WAIT   = 5'd7;
    localparam logic [4:0] S_M_MAG    = 5'd8;
    localparam logic [4:0] S_DIV_GO   = 5'd9;
    localparam logic [4:0] S_DIV_WAIT = 5'd10;
    localparam logic [4:0] S_M_G2     = 5'd11;
    localparam logic [4:0] S_G2_LATCH = 5'd12;
    localparam logic [4:0] S_H_GO     = 5'd13;
    localparam logic [4:0] S_H_WAIT   = 5'd14;
    localparam logic [4:0] S_COR_GO   = 5'd15;
    localparam logic [4:0] S_COR_WAIT = 5'd16;
    localparam logic [4:0] S_M_BW1    = 5'd17;
    localparam logic [4:0] S_M_BW2    = 5'd18;
    localparam logic [4:0] S_BLEND    = 5'd19;
    localparam logic [4:0] S_DONE     = 5'd20;

    localparam int AW = tcf_pkg::AngW;
    localparam int WW = tcf_pkg::WideW;

    // Control state.
    logic [4:0]  state_reg, state_next;
    logic [1:0]  axis_reg, axis_next;
    logic        out_valid_reg, out_valid_next;
    logic        flag_reg, flag_next;
    logic [15:0] blend_w_reg;
    logic [15:0] tick_s_reg;
    logic [15:0] gscale_reg;
    logic signed [AW-1:0] tilt_x_reg, tilt_x_next;
    logic signed [AW-1:0] tilt_y_reg, tilt_y_next;
    logic signed [AW-1:0] head_z_reg, head_z_next;

    // Payload registers.
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic signed [15:0] gx_reg, gy_reg, gz_reg;
    logic [23:0]        ticks_reg;
    logic [39:0]        dt_reg, dt_next;
    logic [31:0]        ax2_reg, ax2_next;
    logic [31:0]        ay2_reg, ay2_next;
    logic [31:0]        msq_reg, msq_next;
    logic [15:0]        g_reg, g_next;
    logic [31:0]        g2_reg, g2_next;
    logic [15:0]        h_reg, h_next;
    logic signed [AW-1:0] px_reg, px_next;
    logic signed [AW-1:0] py_reg, py_next;
    logic signed [AW-1:0] ang_reg, ang_next;
    logic signed [58:0]   t_reg, t_next;
    logic signed [58:0]   prod_reg;
    logic signed [15:0]   ox_reg, oy_reg, oz_reg;
    logic signed [15:0]   ox_next, oy_next, oz_next;
    logic                 of_reg, of_next;

    // Shared multiplier operands.
    logic signed [40:0] mul_a;
    logic signed [17:0] mul_b;

    // Unit connections.
    logic                         sqrt_start, sqrt_done;
    logic [31:0]                  sqrt_rad;
    logic [15:0]                  sqrt_root;
    logic                         div_start, div_done;
    logic [tcf_pkg::DivNumW-1:0]  div_quo;
    logic [tcf_pkg::DivDenW-1:0]  den;
    logic                         cor_start, cor_done;
    logic signed [AW-1:0]         cor_angle;

    // Per-axis selections.
    logic signed [15:0] rate_sel;
    logic [15:0]        rate_abs;
    logic               inc_neg;
    logic signed [WW-1:0] inc;
    logic signed [WW-1:0] acc_sum;
    logic signed [AW-1:0] acc_sel;
    logic signed [AW-1:0] acc_sat;
    logic signed [15:0]   a_sel;
    logic [31:0]          a2_sel;
    logic signed [AW-1:0] p_sel;
    logic signed [58:0]   bsum;
    logic signed [58:0]   bshift;
    logic signed [AW-1:0] blend_sat;

    // Whole degrees, truncated toward zero.
    function automatic logic signed [15:0] to_deg(input logic signed [AW-1:0] q);
        logic signed [15:0] hi;
        hi = q[AW-1:16];
        if (q[AW-1] && (q[15:0] != 16'd0))
        begin
            hi = hi + 16'sd1;
        end
        return hi;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    // Divisor is the gyro scale times 256, with a zero scale read as one.
    assign den = {((gscale_reg == 16'd0) ? 16'd1 : gscale_reg), 8'd0};

    // Rate for the current axis: x uses +rate_y, y uses -rate_x, z uses +rate_z.
    always_comb
    begin
        unique case (axis_reg)
            2'd0:
            begin
                rate_sel = gy_reg;
                inc_neg  = gy_reg[15];
            end
            2'd1:
            begin
                rate_sel = gx_reg;
                inc_neg  = !gx_reg[15] && (gx_reg != 16'sd0);
            end
            default:
            begin
                rate_sel = gz_reg;
                inc_neg  = gz_reg[15];
            end
        endcase
        rate_abs = rate_sel[15] ? (~rate_sel + 16'd1) : rate_sel;
    end

    // Gyro path sum for the current axis, saturated to Q16.16.
    always_comb
    begin
        unique case (axis_reg)
            2'd0:    acc_sel = tilt_x_reg;
            2'd1:    acc_sel = tilt_y_reg;
            default: acc_sel = head_z_reg;
        endcase
        inc = inc_neg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
        acc_sum = WW'(acc_sel) + inc;
        acc_sat = tcf_pkg::sat32(acc_sum);
    end

    // Accelerometer tilt and blend selections for x (axis 0) and y (axis 1).
    always_comb
    begin
        a_sel  = (axis_reg == 2'd0) ? ax_reg : ay_reg;
        a2_sel = (axis_reg == 2'd0) ? ax2_reg : ay2_reg;
        p_sel  = (axis_reg == 2'd0) ? px_reg : py_reg;
        bsum   = t_reg + prod_reg;
        bshift = bsum >>> 16;
        blend_sat = tcf_pkg::sat32(bshift[WW-1:0]);
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        unique case (state_reg)
            S_M_DT:
            begin
                mul_a = $signed({17'd0, ticks_reg});
                mul_b = $signed({2'b00, tick_s_reg});
            end
            S_M_AX2:
            begin
                mul_a = 41'(ax_reg);
                mul_b = 18'(ax_reg);
            end
            S_M_AY2:
            begin
                mul_a = 41'(ay_reg);
                mul_b = 18'(ay_reg);
            end
            S_M_AZ2:
            begin
                mul_a = 41'(az_reg);
                mul_b = 18'(az_reg);
            end
            S_M_MAG:
            begin
                mul_a = $signed({1'b0, dt_reg});
                mul_b = $signed({2'b00, rate_abs});
            end
            S_M_G2:
            begin
                mul_a = $signed({25'd0, g_reg});
                mul_b = $signed({2'b00, g_reg});
            end
            S_M_BW1:
            begin
                mul_a = 41'(p_sel);
                mul_b = $signed({2'b00, blend_w_reg});
            end
            S_M_BW2:
            begin
                mul_a = 41'(ang_reg);
                mul_b = $signed({1'b0, 17'(18'd65536 - {2'b00, blend_w_reg})});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Unit start strobes and operands.
    assign sqrt_start = (state_reg == S_G_GO) || (state_reg == S_H_GO);
    assign sqrt_rad   = (state_reg == S_G_GO) ? msq_reg : (g2_reg - a2_sel);
    assign div_start  = (state_reg == S_DIV_GO);
    assign cor_start  = (state_reg == S_COR_GO);

    tcf_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_rad),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    tcf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg[tcf_pkg::DivNumW-1:0]),
        .divisor  (den),
        .quotient (div_quo),
        .done     (div_done)
    );

    tcf_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .a     (a_sel),
        .h     (h_reg),
        .angle (cor_angle),
        .done  (cor_done)
    );

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg;
        flag_next      = flag_reg;
        tilt_x_next    = tilt_x_reg;
        tilt_y_next    = tilt_y_reg;
        head_z_next    = head_z_reg;
        dt_next        = dt_reg;
        ax2_next       = ax2_reg;
        ay2_next       = ay2_reg;
        msq_next       = msq_reg;
        g_next         = g_reg;
        g2_next        = g2_reg;
        h_next         = h_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        ang_next       = ang_reg;
        t_next         = t_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        oz_next        = oz_reg;
        of_next        = of_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_M_DT;
                end
            end
            S_M_DT:
            begin
                state_next = S_M_AX2;
            end
            S_M_AX2:
            begin
                dt_next    = prod_reg[39:0];
                state_next = S_M_AY2;
            end
            S_M_AY2:
            begin
                ax2_next   = prod_reg[31:0];
                msq_next   = prod_reg[31:0];
                state_next = S_M_AZ2;
            end
            S_M_AZ2:
            begin
                ay2_next   = prod_reg[31:0];
                msq_next   = msq_reg + prod_reg[31:0];
                state_next = S_SQ_SUM;
            end
            S_SQ_SUM:
            begin
                msq_next   = msq_reg + prod_reg[31:0];
                axis_next  = 2'd0;
                state_next = S_G_GO;
            end
            S_G_GO:
            begin
                state_next = S_G_WAIT;
            end
            S_G_WAIT:
            begin
                if (sqrt_done)
                begin
                    g_next     = sqrt_root;
                    state_next = S_M_MAG;
                end
            end
            S_M_MAG:
            begin
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    unique case (axis_reg)
                        2'd0:    px_next     = acc_sat;
                        2'd1:    py_next     = acc_sat;
                        default: head_z_next = acc_sat;
                    endcase
                    if (axis_reg == 2'd2)
                    begin
                        axis_next = 2'd0;
                        if (g_reg == 16'd0)
                        begin
                            // No gravity vector: the gyro path stands alone.
                            tilt_x_next = px_reg;
                            tilt_y_next = py_reg;
                            flag_next   = 1'b1;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            flag_next  = 1'b0;
                            state_next = S_M_G2;
                        end
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_M_MAG;
                    end
                end
            end
            S_M_G2:
            begin
                state_next = S_G2_LATCH;
            end
            S_G2_LATCH:
            begin
                g2_next    = prod_reg[31:0];
                state_next = S_H_GO;
            end
            S_H_GO:
            begin
                state_next = S_H_WAIT;
            end
            S_H_WAIT:
            begin
                if (sqrt_done)
                begin
                    h_next     = sqrt_root;
                    state_next = S_COR_GO;
                end
            end
            S_COR_GO:
            begin
                state_next = S_COR_WAIT;
            end
            S_COR_WAIT:
            begin
                if (cor_done)
                begin
                    ang_next   = cor_angle - tcf_pkg::Deg90Q16;
                    state_next = S_M_BW1;
                end
            end
            S_M_BW1:
            begin
                state_next = S_M_BW2;
            end
            S_M_BW2:
            begin
                t_next     = prod_reg;
                state_next = S_BLEND;
            end
            S_BLEND:
            begin
                if (axis_reg == 2'd0)
                begin
                    tilt_x_next = blend_sat;
                    axis_next   = 2'd1;
                    state_next  = S_H_GO;
                end
                else
                begin
                    tilt_y_next = blend_sat;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ox_next        = to_deg(tilt_x_reg);
                    oy_next        = to_deg(tilt_y_reg);
                    oz_next        = to_deg(head_z_reg);
                    of_next        = flag_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and filter state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
            flag_reg      <= 1'b0;
            tilt_x_reg    <= '0;
            tilt_y_reg    <= '0;
            head_z_reg    <= '0;
            blend_w_reg   <= 16'd52429;
            tick_s_reg    <= 16'd4660;
            gscale_reg    <= 16'd4198;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            flag_reg      <= flag_next;
            tilt_x_reg    <= tilt_x_next;
            tilt_y_reg    <= tilt_y_next;
            head_z_reg    <= head_z_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CfgBlendWeight: blend_w_reg <= cfg_data;
                    CfgTickSeconds: tick_s_reg  <= cfg_data;
                    CfgGyroScale:   gscale_reg  <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // Input capture and datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ax_reg    <= accel_x;
            ay_reg    <= accel_y;
            az_reg    <= accel_z;
            gx_reg    <= rate_x;
            gy_reg    <= rate_y;
            gz_reg    <= rate_z;
            ticks_reg <= elapsed_ticks;
        end
        prod_reg <= mul_a * mul_b;
        dt_reg   <= dt_next;
        ax2_reg  <= ax2_next;
        ay2_reg  <= ay2_next;
        msq_reg  <= msq_next;
        g_reg    <= g_next;
        g2_reg   <= g2_next;
        h_reg    <= h_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        ang_reg  <= ang_next;
        t_reg    <= t_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        oz_reg   <= oz_next;
        of_reg   <= of_next;
    end

    assign out_valid   = out_valid_reg;
    assign angle_x_deg = ox_reg;
    assign angle_y_deg = oy_reg;
    assign angle_z_deg = oz_reg;
    assign no_gravity  = of_reg;

    // An accepted word always starts a run, so the block is busy right after.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a run was not started");

    // A finished result never overwrites a word still waiting downstream.
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_valid_reg && !out_ready |=> state_reg == S_DONE)
        else $error("result register overwritten while stalled");

    // Each unit reports completion only while the sequencer waits for it.
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV_WAIT)
        else $error("divider finished outside its wait state");

    a_sqrt_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> state_reg == S_G_WAIT || state_reg == S_H_WAIT)
        else $error("square root finished outside its wait state");

    a_cor_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cor_done |-> state_reg == S_COR_WAIT)
        else $error("CORDIC finished outside its wait state");

endmodule
